// File: src/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants for the power switch sequencer.
// ----------------------------------------------------------------------------
package pss_pkg;

   // item kinds carried on the request channel
   typedef enum logic [1:0] {
      FUNC_TICK      = 2'd0,
      FUNC_LOOP      = 2'd1,
      FUNC_WR_SHDN   = 2'd2,
      FUNC_WR_PWRUP  = 2'd3
   } func_type;

   // classified selector position
   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_FORCED = 2'd1,
      MODE_AUTO   = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   // position codes placed in the top bits of the switch report
   localparam logic [1:0] REPORT_CODE_OFF  = 2'd1;
   localparam logic [1:0] REPORT_CODE_ON   = 2'd3;
   localparam logic [1:0] REPORT_CODE_AUTO = 2'd2;

   localparam int unsigned SAMPLE_W = 10;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned REPORT_W = 16;
   localparam int unsigned CODE_LSB = 14;

   // configuration register indexes (byte address is 4 * index)
   localparam logic [1:0] REG_LOW_THRESH  = 2'd0;
   localparam logic [1:0] REG_HIGH_THRESH = 2'd1;
   localparam logic [1:0] REG_SHDN_DELAY  = 2'd2;

   localparam logic [SAMPLE_W-1:0] LOW_THRESH_RESET  = 10'd300;
   localparam logic [SAMPLE_W-1:0] HIGH_THRESH_RESET = 10'd700;
   localparam logic [COUNT_W-1:0]  SHDN_DELAY_RESET  = 16'd60;

   // configuration seen by the sequencing core
   typedef struct packed {
      logic [SAMPLE_W-1:0] low_thresh;
      logic [SAMPLE_W-1:0] high_thresh;
      logic [COUNT_W-1:0]  shdn_delay;
   } cfg_type;

endpackage

// File: src/pss_csr.sv
// ----------------------------------------------------------------------------
// pss_csr
// Configuration registers behind an APB-style port: thresholds and delay.
// ----------------------------------------------------------------------------
module pss_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output pss_pkg::cfg_type   cfg
);

   logic [pss_pkg::SAMPLE_W-1:0] low_thresh_ff;
   logic [pss_pkg::SAMPLE_W-1:0] high_thresh_ff;
   logic [pss_pkg::COUNT_W-1:0]  shdn_delay_ff;
   logic [1:0]                   reg_idx;
   logic                         wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // write the addressed register; writes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         low_thresh_ff  <= pss_pkg::LOW_THRESH_RESET;
         high_thresh_ff <= pss_pkg::HIGH_THRESH_RESET;
         shdn_delay_ff  <= pss_pkg::SHDN_DELAY_RESET;
      end else if (wr_en) begin
         if (reg_idx == pss_pkg::REG_LOW_THRESH) begin
            low_thresh_ff <= csr_pwdata[pss_pkg::SAMPLE_W-1:0];
         end
         if (reg_idx == pss_pkg::REG_HIGH_THRESH) begin
            high_thresh_ff <= csr_pwdata[pss_pkg::SAMPLE_W-1:0];
         end
         if (reg_idx == pss_pkg::REG_SHDN_DELAY) begin
            shdn_delay_ff <= csr_pwdata[pss_pkg::COUNT_W-1:0];
         end
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      if (reg_idx == pss_pkg::REG_LOW_THRESH) begin
         csr_prdata = {22'd0, low_thresh_ff};
      end else if (reg_idx == pss_pkg::REG_HIGH_THRESH) begin
         csr_prdata = {22'd0, high_thresh_ff};
      end else if (reg_idx == pss_pkg::REG_SHDN_DELAY) begin
         csr_prdata = {16'd0, shdn_delay_ff};
      end
   end

   assign cfg.low_thresh  = low_thresh_ff;
   assign cfg.high_thresh = high_thresh_ff;
   assign cfg.shdn_delay  = shdn_delay_ff;

endmodule

// File: src/pss_core.sv
// ----------------------------------------------------------------------------
// pss_core
// Sequencer state, per-item update logic and the result register.
// ----------------------------------------------------------------------------
module pss_core (
   input  logic                          clock,
   input  logic                          reset,
   input  pss_pkg::cfg_type              cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  pss_pkg::func_type             req_func,
   input  logic [pss_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic [pss_pkg::COUNT_W-1:0]   req_wval,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_power_enable,
   output pss_pkg::mode_type             rsp_mode,
   output logic [pss_pkg::REPORT_W-1:0]  rsp_report,
   output logic [pss_pkg::COUNT_W-1:0]   rsp_shdn_remaining,
   output logic [pss_pkg::COUNT_W-1:0]   rsp_pwrup_remaining,
   output logic                          rsp_deep_sleep
);

   // sequencer state
   logic                          output_on_ff,   output_on_in;
   logic                          shdn_pend_ff,   shdn_pend_in;
   logic                          pwrup_pend_ff,  pwrup_pend_in;
   logic [pss_pkg::COUNT_W-1:0]   shdn_cnt_ff,    shdn_cnt_in;
   logic [pss_pkg::COUNT_W-1:0]   pwrup_cnt_ff,   pwrup_cnt_in;
   logic [pss_pkg::REPORT_W-1:0]  report_ff,      report_in;
   pss_pkg::mode_type             mode_ff,        mode_in;

   // result register
   logic                          rsp_valid_ff,   rsp_valid_in;
   logic                          res_pe_ff;
   pss_pkg::mode_type             res_mode_ff;
   logic [pss_pkg::REPORT_W-1:0]  res_report_ff;
   logic [pss_pkg::COUNT_W-1:0]   res_shdn_ff;
   logic [pss_pkg::COUNT_W-1:0]   res_pwrup_ff;

   logic                          accept;
   pss_pkg::mode_type             cls_mode;
   logic [1:0]                    cls_code;

   // take a new item whenever the result slot is empty or being drained
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   // classify the selector sample; the off test wins when thresholds cross
   always_comb begin
      if (req_sample < cfg.low_thresh) begin
         cls_mode = pss_pkg::MODE_OFF;
         cls_code = pss_pkg::REPORT_CODE_OFF;
      end else if (req_sample < cfg.high_thresh) begin
         cls_mode = pss_pkg::MODE_FORCED;
         cls_code = pss_pkg::REPORT_CODE_ON;
      end else begin
         cls_mode = pss_pkg::MODE_AUTO;
         cls_code = pss_pkg::REPORT_CODE_AUTO;
      end
   end

   // next state for the item on the request channel
   always_comb begin
      output_on_in  = output_on_ff;
      shdn_pend_in  = shdn_pend_ff;
      pwrup_pend_in = pwrup_pend_ff;
      shdn_cnt_in   = shdn_cnt_ff;
      pwrup_cnt_in  = pwrup_cnt_ff;
      report_in     = report_ff;
      mode_in       = mode_ff;
      unique case (req_func)
         pss_pkg::FUNC_TICK: begin
            // count down nonzero counters, flag the step that lands on zero
            if (shdn_cnt_ff != '0) begin
               shdn_cnt_in = shdn_cnt_ff - 1'b1;
               if (shdn_cnt_ff == pss_pkg::COUNT_W'(1)) begin
                  shdn_pend_in = 1'b1;
               end
            end
            if (pwrup_cnt_ff != '0) begin
               pwrup_cnt_in = pwrup_cnt_ff - 1'b1;
               if (pwrup_cnt_ff == pss_pkg::COUNT_W'(1)) begin
                  pwrup_pend_in = 1'b1;
               end
            end
         end
         pss_pkg::FUNC_LOOP: begin
            mode_in   = cls_mode;
            report_in = {cls_code,
                         (pss_pkg::CODE_LSB - pss_pkg::SAMPLE_W)'(0),
                         req_sample};
            if (cls_mode != pss_pkg::MODE_AUTO) begin
               output_on_in  = (cls_mode == pss_pkg::MODE_FORCED);
               pwrup_pend_in = 1'b1;
               shdn_cnt_in   = cfg.shdn_delay;
            end else if (output_on_ff) begin
               if (shdn_pend_ff) begin
                  shdn_pend_in  = 1'b0;
                  pwrup_pend_in = 1'b0;
                  output_on_in  = 1'b0;
               end
            end else if (pwrup_pend_ff) begin
               shdn_pend_in  = 1'b0;
               pwrup_pend_in = 1'b0;
               output_on_in  = 1'b1;
            end
         end
         pss_pkg::FUNC_WR_SHDN: begin
            shdn_cnt_in = req_wval;
         end
         pss_pkg::FUNC_WR_PWRUP: begin
            pwrup_cnt_in = req_wval;
         end
         default: begin
            shdn_cnt_in = shdn_cnt_ff;
         end
      endcase
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & ~rsp_ready);

   // advance state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         output_on_ff  <= 1'b0;
         shdn_pend_ff  <= 1'b0;
         pwrup_pend_ff <= 1'b1;
         shdn_cnt_ff   <= pss_pkg::SHDN_DELAY_RESET;
         pwrup_cnt_ff  <= '0;
         report_ff     <= '0;
         mode_ff       <= pss_pkg::MODE_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            output_on_ff  <= output_on_in;
            shdn_pend_ff  <= shdn_pend_in;
            pwrup_pend_ff <= pwrup_pend_in;
            shdn_cnt_ff   <= shdn_cnt_in;
            pwrup_cnt_ff  <= pwrup_cnt_in;
            report_ff     <= report_in;
            mode_ff       <= mode_in;
         end
      end
   end

   // load the result item, hold it while the consumer stalls
   always_ff @(posedge clock) begin
      if (accept) begin
         res_pe_ff     <= output_on_in;
         res_mode_ff   <= mode_in;
         res_report_ff <= report_in;
         res_shdn_ff   <= shdn_cnt_in;
         res_pwrup_ff  <= pwrup_cnt_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_power_enable    = res_pe_ff;
   assign rsp_mode            = res_mode_ff;
   assign rsp_report          = res_report_ff;
   assign rsp_shdn_remaining  = res_shdn_ff;
   assign rsp_pwrup_remaining = res_pwrup_ff;
   assign rsp_deep_sleep      = ~res_pe_ff;

`ifndef SYNTHESIS
   // an accepted item always leaves a result behind
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   // off position drops the output drive
   a_off_drops_output: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == pss_pkg::FUNC_LOOP && req_sample < cfg.low_thresh)
      |=> (!output_on_ff && pwrup_pend_ff && mode_ff == pss_pkg::MODE_OFF))
      else $error("off position did not stop the output");

   // shutdown countdown reaching zero raises its flag
   a_shdn_expiry_flags: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == pss_pkg::FUNC_TICK && shdn_cnt_ff == 16'd1)
      |=> (shdn_pend_ff && shdn_cnt_ff == '0))
      else $error("shutdown expiry did not raise its flag");

   // result register tracks the state it was loaded from
   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      accept |=> (res_pe_ff == output_on_ff && res_shdn_ff == shdn_cnt_ff
                  && res_pwrup_ff == pwrup_cnt_ff))
      else $error("result item differs from sequencer state");
`endif

endmodule

// File: src/power_switch_sequencer.sv
// ----------------------------------------------------------------------------
// power_switch_sequencer
// Supply output sequencer driven by a selector switch and two countdowns.
//
//   channel  dir  handshake           payload
//   req      in   tvalid/tready       tuser: func; tdata: sample, write value
//   rsp      out  tvalid/tready       tdata: enable, mode, report, counts, sleep
//   csr      in   psel/penable/pready low/high threshold, shutdown delay
//
// One item per cycle while results drain; a result appears in the cycle after
// its item is taken, from a combinational compare, decrement and select.
// Reset loads the sequencer start state (power-up flag set) and register defaults.
// A stalled result stays in the result register; a new item is still taken
// in the cycle the consumer drains it.
// ----------------------------------------------------------------------------
module power_switch_sequencer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [9:0] switch_sample, [25:10] write_value
   input  logic [1:0]  req_tuser,  // [1:0] func
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // [0] power_enable, [2:1] switch_mode,
                                   // [18:3] switch_report,
                                   // [34:19] shutdown_remaining,
                                   // [50:35] powerup_remaining, [51] deep_sleep
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   pss_pkg::cfg_type              cfg;
   logic                          rsp_pe;
   pss_pkg::mode_type             rsp_mode;
   logic [pss_pkg::REPORT_W-1:0]  rsp_report;
   logic [pss_pkg::COUNT_W-1:0]   rsp_shdn;
   logic [pss_pkg::COUNT_W-1:0]   rsp_pwrup;
   logic                          rsp_sleep;

   pss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pss_core u_core (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .req_valid           (req_tvalid),
      .req_ready           (req_tready),
      .req_func            (pss_pkg::func_type'(req_tuser)),
      .req_sample          (req_tdata[9:0]),
      .req_wval            (req_tdata[25:10]),
      .rsp_valid           (rsp_tvalid),
      .rsp_ready           (rsp_tready),
      .rsp_power_enable    (rsp_pe),
      .rsp_mode            (rsp_mode),
      .rsp_report          (rsp_report),
      .rsp_shdn_remaining  (rsp_shdn),
      .rsp_pwrup_remaining (rsp_pwrup),
      .rsp_deep_sleep      (rsp_sleep)
   );

   // pack the result item, highest field first
   assign rsp_tdata = {4'd0, rsp_sleep, rsp_pwrup, rsp_shdn, rsp_report,
                       rsp_mode, rsp_pe};

endmodule

// File: tb/sv/pss_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_status_checker
// Watches the request, result and register ports of the power switch
// sequencer, predicts the status item each request should produce and
// compares every returned status item with the oldest prediction.
// ----------------------------------------------------------------------------
module pss_status_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [9:0] switch_sample, [25:10] write_value
   input  logic [1:0]  req_tuser,   // [1:0] func
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,   // [0] power_enable, [2:1] switch_mode,
                                    // [18:3] switch_report,
                                    // [34:19] shutdown_remaining,
                                    // [50:35] powerup_remaining, [51] deep_sleep
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          mismatches,
   output int          backlog,
   output int          compared
);

   // sequencer state as tracked here
   typedef struct packed {
      logic                         drive_on;
      logic                         shdn_due;
      logic                         pwrup_due;
      logic [pss_pkg::COUNT_W-1:0]  shdn_count;
      logic [pss_pkg::COUNT_W-1:0]  pwrup_count;
      logic [pss_pkg::REPORT_W-1:0] report;
      pss_pkg::mode_type            mode;
   } supply_state_type;

   // status item, laid out exactly as on rsp_tdata (last member lowest)
   typedef struct packed {
      logic [3:0]                   pad;
      logic                         deep_sleep;
      logic [pss_pkg::COUNT_W-1:0]  pwrup_left;
      logic [pss_pkg::COUNT_W-1:0]  shdn_left;
      logic [pss_pkg::REPORT_W-1:0] report;
      pss_pkg::mode_type            mode;
      logic                         enable;
   } supply_status_type;

   logic [pss_pkg::SAMPLE_W-1:0] low_thresh;
   logic [pss_pkg::SAMPLE_W-1:0] high_thresh;
   logic [pss_pkg::COUNT_W-1:0]  shdn_reload;
   supply_state_type             supply;
   supply_status_type            expected_status [$];
   supply_status_type            got;
   supply_status_type            want;
   int                           err_total  = 0;
   int                           seen_total = 0;

   // apply one request to the tracked state
   function automatic supply_state_type advance_supply(
         input supply_state_type s,
         input pss_pkg::func_type kind,
         input logic [pss_pkg::SAMPLE_W-1:0] sample,
         input logic [pss_pkg::COUNT_W-1:0] value);
      logic [1:0] code;
      case (kind)
         pss_pkg::FUNC_TICK: begin
            // a countdown parked at zero stays there and raises nothing
            if (s.shdn_count != 0) begin
               s.shdn_count = s.shdn_count - 1'b1;
               if (s.shdn_count == 0) s.shdn_due = 1'b1;
            end
            if (s.pwrup_count != 0) begin
               s.pwrup_count = s.pwrup_count - 1'b1;
               if (s.pwrup_count == 0) s.pwrup_due = 1'b1;
            end
         end
         pss_pkg::FUNC_LOOP: begin
            // off test first, so crossed thresholds never yield forced on
            if (sample < low_thresh) begin
               s.mode = pss_pkg::MODE_OFF;
               code   = pss_pkg::REPORT_CODE_OFF;
            end else if (sample < high_thresh) begin
               s.mode = pss_pkg::MODE_FORCED;
               code   = pss_pkg::REPORT_CODE_ON;
            end else begin
               s.mode = pss_pkg::MODE_AUTO;
               code   = pss_pkg::REPORT_CODE_AUTO;
            end
            s.report = pss_pkg::REPORT_W'(sample) |
                       (pss_pkg::REPORT_W'(code) << pss_pkg::CODE_LSB);
            if (s.mode != pss_pkg::MODE_AUTO) begin
               // shutdown flag is left alone here
               s.drive_on   = (s.mode == pss_pkg::MODE_FORCED);
               s.pwrup_due  = 1'b1;
               s.shdn_count = shdn_reload;
            end else if (s.drive_on) begin
               if (s.shdn_due) begin
                  s.shdn_due  = 1'b0;
                  s.pwrup_due = 1'b0;
                  s.drive_on  = 1'b0;
               end
            end else if (s.pwrup_due) begin
               s.pwrup_due = 1'b0;
               s.shdn_due  = 1'b0;
               s.drive_on  = 1'b1;
            end
         end
         pss_pkg::FUNC_WR_SHDN: s.shdn_count = value;
         default:               s.pwrup_count = value;
      endcase
      return s;
   endfunction

   // track registers, predict on each request item, check each status item
   always @(posedge clock) begin
      if (reset) begin
         low_thresh  = pss_pkg::LOW_THRESH_RESET;
         high_thresh = pss_pkg::HIGH_THRESH_RESET;
         shdn_reload = pss_pkg::SHDN_DELAY_RESET;
         supply = '{drive_on: 1'b0, shdn_due: 1'b0, pwrup_due: 1'b1,
                    shdn_count: pss_pkg::SHDN_DELAY_RESET, pwrup_count: '0,
                    report: '0, mode: pss_pkg::MODE_NONE};
         expected_status.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               pss_pkg::REG_LOW_THRESH:
                  low_thresh  = csr_pwdata[pss_pkg::SAMPLE_W-1:0];
               pss_pkg::REG_HIGH_THRESH:
                  high_thresh = csr_pwdata[pss_pkg::SAMPLE_W-1:0];
               pss_pkg::REG_SHDN_DELAY:
                  shdn_reload = csr_pwdata[pss_pkg::COUNT_W-1:0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            supply = advance_supply(supply, pss_pkg::func_type'(req_tuser),
                                    req_tdata[9:0], req_tdata[25:10]);
            want = '{pad: '0, deep_sleep: ~supply.drive_on,
                     pwrup_left: supply.pwrup_count, shdn_left: supply.shdn_count,
                     report: supply.report, mode: supply.mode,
                     enable: supply.drive_on};
            expected_status.push_back(want);
         end

         if (rsp_tvalid && rsp_tready) begin
            got = supply_status_type'(rsp_tdata);
            seen_total++;
            if (expected_status.size() == 0) begin
               err_total++;
               if (err_total <= 10)
                  $display("status item %h arrived with nothing pending", rsp_tdata);
            end else begin
               want = expected_status.pop_front();
               if (got.enable !== want.enable || got.mode !== want.mode ||
                   got.report !== want.report || got.shdn_left !== want.shdn_left ||
                   got.pwrup_left !== want.pwrup_left ||
                   got.deep_sleep !== want.deep_sleep || got.pad !== want.pad) begin
                  err_total++;
                  if (err_total <= 10)
                     $display({"status item %0d (expected/actual): enable %0d/%0d ",
                               "mode %0d/%0d report %h/%h shutdown %0d/%0d ",
                               "powerup %0d/%0d sleep %0d/%0d pad %h/%h"},
                              seen_total, want.enable, got.enable, want.mode, got.mode,
                              want.report, got.report, want.shdn_left, got.shdn_left,
                              want.pwrup_left, got.pwrup_left,
                              want.deep_sleep, got.deep_sleep, want.pad, got.pad);
               end
            end
         end
      end
      mismatches <= err_total;
      backlog    <= expected_status.size();
      compared   <= seen_total;
   end

endmodule

// File: tb/sv/power_switch_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_switch_sequencer_test
// Drives the power switch sequencer with directed corner cases and then
// random ticks, loop passes and countdown writes under several register
// settings and idle mixes; the status checker predicts and compares.
// ----------------------------------------------------------------------------
module power_switch_sequencer_test;

   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 141;
   localparam int WATCHDOG_LIMIT = 2000;

   // register slot past the last one, writes there must be ignored
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mix_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = pss_pkg::FUNC_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b1;
   logic [55:0] rsp_tdata;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          mismatches;
   int          backlog;
   int          compared;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          items_sent    = 0;
   int          quiet_cycles  = 0;
   logic [pss_pkg::SAMPLE_W-1:0] cur_low  = pss_pkg::LOW_THRESH_RESET;
   logic [pss_pkg::SAMPLE_W-1:0] cur_high = pss_pkg::HIGH_THRESH_RESET;

   power_switch_sequencer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pss_status_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .mismatches  (mismatches),
      .backlog     (backlog),
      .compared    (compared)
   );

   always #5 clock = ~clock;

   // stall the result channel at random
   always @(posedge clock) begin
      rsp_tready <= (int'($urandom_range(99)) >= stall_pct);
   end

   // end the run if no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles without any handshake", quiet_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // any selector reading
   function automatic logic [pss_pkg::SAMPLE_W-1:0] rand_sample();
      return pss_pkg::SAMPLE_W'($urandom_range(1023));
   endfunction

   // any countdown value
   function automatic logic [pss_pkg::COUNT_W-1:0] rand_value();
      return pss_pkg::COUNT_W'($urandom_range(65535));
   endfunction

   // offer one request item, idling first at random, and hold until taken
   task automatic send_item(input pss_pkg::func_type kind,
                            input logic [pss_pkg::SAMPLE_W-1:0] sample,
                            input logic [pss_pkg::COUNT_W-1:0] value);
      while (int'($urandom_range(99)) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, value, sample};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // sample within one step of a threshold
   function automatic logic [pss_pkg::SAMPLE_W-1:0] near_thresh(
         input logic [pss_pkg::SAMPLE_W-1:0] thresh);
      int v;
      v = int'(thresh) + int'($urandom_range(2)) - 1;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return v[pss_pkg::SAMPLE_W-1:0];
   endfunction

   // random request item, biased toward short countdowns and threshold edges
   task automatic send_random_item();
      pss_pkg::func_type            kind;
      logic [pss_pkg::SAMPLE_W-1:0] sample;
      logic [pss_pkg::COUNT_W-1:0]  value;
      int unsigned                  pick;
      pick = $urandom_range(99);
      if (pick < 45)      kind = pss_pkg::FUNC_TICK;
      else if (pick < 75) kind = pss_pkg::FUNC_LOOP;
      else if (pick < 88) kind = pss_pkg::FUNC_WR_SHDN;
      else                kind = pss_pkg::FUNC_WR_PWRUP;
      case ($urandom_range(3))
         0:       sample = rand_sample();
         1:       sample = near_thresh(cur_low);
         2:       sample = near_thresh(cur_high);
         default: sample = $urandom_range(1) ? '1 : '0;
      endcase
      case ($urandom_range(9))
         0:       value = rand_value();
         1:       value = '0;
         default: value = pss_pkg::COUNT_W'($urandom_range(6, 1));
      endcase
      send_item(kind, sample, value);
   endtask

   // one register write: setup cycle, then access until pready
   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   // load all three registers (and optionally the unused slot), with junk above each register's width
   task automatic program_settings(input logic [pss_pkg::SAMPLE_W-1:0] low,
                                   input logic [pss_pkg::SAMPLE_W-1:0] high,
                                   input logic [pss_pkg::COUNT_W-1:0] delay,
                                   input logic poke_unused);
      logic [31:0] noise;
      noise = $urandom;
      write_reg(pss_pkg::REG_LOW_THRESH, {noise[31:10], low});
      noise = $urandom;
      write_reg(pss_pkg::REG_HIGH_THRESH, {noise[31:10], high});
      noise = $urandom;
      write_reg(pss_pkg::REG_SHDN_DELAY, {noise[31:16], delay});
      if (poke_unused) write_reg(REG_UNUSED, $urandom);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      cur_low  = low;
      cur_high = high;
   endtask

   // drop valid and wait until every status item has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
   endtask

   initial begin
      logic [pss_pkg::SAMPLE_W-1:0] low_pick;
      logic [pss_pkg::SAMPLE_W-1:0] high_pick;
      logic [pss_pkg::COUNT_W-1:0]  delay_pick;
      idle_mix_type                 mix;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: countdowns, every position, flag interplay, field extremes
      send_item(pss_pkg::FUNC_TICK, rand_sample(), rand_value());
      send_item(pss_pkg::FUNC_LOOP, 10'd0, rand_value());
      send_item(pss_pkg::FUNC_LOOP, 10'h3ff, rand_value());
      send_item(pss_pkg::FUNC_WR_SHDN, rand_sample(), 16'd2);
      send_item(pss_pkg::FUNC_TICK, rand_sample(), rand_value());
      send_item(pss_pkg::FUNC_TICK, rand_sample(), rand_value());
      send_item(pss_pkg::FUNC_LOOP, 10'd700, rand_value());
      send_item(pss_pkg::FUNC_WR_PWRUP, rand_sample(), 16'hffff);
      send_item(pss_pkg::FUNC_WR_PWRUP, rand_sample(), 16'd1);
      send_item(pss_pkg::FUNC_TICK, rand_sample(), rand_value());
      send_item(pss_pkg::FUNC_LOOP, 10'd699, rand_value());
      send_item(pss_pkg::FUNC_LOOP, 10'd300, rand_value());
      send_item(pss_pkg::FUNC_LOOP, 10'd299, rand_value());
      // stopped countdown: a tick must leave it at zero
      send_item(pss_pkg::FUNC_WR_SHDN, rand_sample(), 16'd0);
      send_item(pss_pkg::FUNC_TICK, rand_sample(), rand_value());
      // both flags raised while off, then while on
      send_item(pss_pkg::FUNC_WR_SHDN, rand_sample(), 16'd1);
      send_item(pss_pkg::FUNC_WR_PWRUP, rand_sample(), 16'd1);
      send_item(pss_pkg::FUNC_TICK, rand_sample(), rand_value());
      send_item(pss_pkg::FUNC_LOOP, 10'h3ff, rand_value());
      send_item(pss_pkg::FUNC_WR_SHDN, rand_sample(), 16'd1);
      send_item(pss_pkg::FUNC_WR_PWRUP, rand_sample(), 16'd1);
      send_item(pss_pkg::FUNC_TICK, rand_sample(), rand_value());
      send_item(pss_pkg::FUNC_LOOP, 10'h3ff, rand_value());
      // shutdown flag must survive a forced-on pass
      send_item(pss_pkg::FUNC_WR_SHDN, rand_sample(), 16'd1);
      send_item(pss_pkg::FUNC_TICK, rand_sample(), rand_value());
      send_item(pss_pkg::FUNC_LOOP, 10'h2aa, rand_value());
      send_item(pss_pkg::FUNC_LOOP, 10'h155, rand_value());
      send_item(pss_pkg::FUNC_LOOP, 10'h3ff, rand_value());
      send_item(pss_pkg::FUNC_WR_SHDN, rand_sample(), 16'h5555);
      send_item(pss_pkg::FUNC_WR_PWRUP, rand_sample(), 16'haaaa);

      // random phases, each with its own settings and one of four idle mixes
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         mix = idle_mix_type'(phase % 4);
         case (mix)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 87; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 87; end
            default:       begin send_idle_pct = 25; stall_pct = 25; end
         endcase
         case (phase)
            0: begin low_pick = 10'd0;    high_pick = 10'd0;    delay_pick = 16'd0;     end
            1: begin low_pick = 10'd1023; high_pick = 10'd1023; delay_pick = 16'hffff;  end
            2: begin low_pick = 10'd800;  high_pick = 10'd200;  delay_pick = 16'd3;     end
            3: begin low_pick = 10'd300;  high_pick = 10'd700;  delay_pick = 16'd60;    end
            4: begin
               low_pick   = rand_sample();
               high_pick  = rand_sample();
               delay_pick = pss_pkg::COUNT_W'($urandom_range(10, 1));
            end
            5: begin low_pick = 10'd100;  high_pick = 10'd900;  delay_pick = 16'd1;     end
            6: begin low_pick = 10'd512;  high_pick = 10'd513;  delay_pick = 16'd2;     end
            default: begin
               low_pick   = rand_sample();
               high_pick  = rand_sample();
               delay_pick = rand_value();
            end
         endcase
         program_settings(low_pick, high_pick, delay_pick, phase == 2);
         repeat (PHASE_ITEMS) send_random_item();
      end

      wait_drained();
      repeat (4) @(posedge clock);

      $display("covered %0d items: directed corner cases, then %0d register settings",
               items_sent, PHASES);
      $display("under four idle mixes; %0d status items compared, %0d mismatches",
               compared, mismatches);
      if (mismatches == 0 && backlog == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
